@@ rtl/pva_pkg.sv @@
// shared constants, codes and control types of the priority voice allocator
`timescale 1ns / 1ps

package pva_pkg;

    // pool and sound table sizes
    localparam int VOICES      = 4;
    localparam int SOUND_SLOTS = 256;

    // derived widths
    localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int PLAY_W  = VOICE_W + 1;
    localparam int STEPS   = (VOICES > 3) ? VOICES : 3;
    localparam int STEP_W  = $clog2(STEPS);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOUND_COUNT   = 1'b0,
        REG_MASTER_VOLUME = 1'b1
    } reg_idx_t;

    // priorities
    localparam logic signed [31:0] PRIO_RESET = -32'sd9999999;
    localparam logic signed [31:0] PRIO_LOOP  = 32'sd65535;
    localparam logic signed [31:0] PRIO_MAX   = 32'sh7fff_ffff;

    // level scaling: floor(x / 10000) = ((x >> 4) * RECIP_625) >> RECIP_SHIFT
    localparam logic [18:0] RECIP_625   = 19'd429497;
    localparam int          RECIP_SHIFT = 28;

    // request codes
    typedef enum logic [3:0] {
        OP_PLAY       = 4'd0,
        OP_LOOP       = 4'd1,
        OP_STOP_SOUND = 4'd2,
        OP_STOP_VOICE = 4'd3,
        OP_MOVE_SOUND = 4'd4,
        OP_MOVE_VOICE = 4'd5,
        OP_PAUSE      = 4'd6,
        OP_RESUME     = 4'd7,
        OP_STOP_ALL   = 4'd8,
        OP_FINISHED   = 4'd9,
        OP_QUERY_SND  = 4'd10,
        OP_QUERY_VOICE = 4'd11
    } op_t;

    // result command codes
    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_RESTART = 3'd2,
        CMD_SILENCE = 3'd3,
        CMD_SET_VOL = 3'd4,
        CMD_NOTIFY  = 3'd5
    } cmd_code_t;

    // controller to datapath
    typedef struct packed {
        logic              capture;
        logic              prod;
        logic              scale;
        logic              quot;
        logic              fire;
        logic [STEP_W-1:0] step;
    } pva_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;
        logic last;
    } pva_stat_t;

endpackage

@@ rtl/pva_dpath.sv @@
// datapath of the voice allocator: voice tables, level arithmetic, result register
`timescale 1ns / 1ps

module pva_dpath import pva_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic [3:0]                  s_operation,
    input  logic signed [15:0]          s_sound_index,
    input  logic signed [15:0]          s_voice,
    input  logic signed [7:0]           s_balance,
    input  logic [7:0]                  s_loudness,
    input  logic signed [31:0]          s_request_priority,
    input  pva_cmd_t                    cmd,
    output pva_stat_t                   stat,
    output logic [2:0]                  m_command,
    output logic [VOICE_W-1:0]          m_target_voice,
    output logic [7:0]                  m_sound_out,
    output logic [7:0]                  m_left_level,
    output logic [7:0]                  m_right_level,
    output logic signed [PLAY_W-1:0]    m_play_result,
    output logic                        m_is_playing,
    output logic                        m_last
);

    localparam logic [16:0] SLOT_LIMIT  = 17'(SOUND_SLOTS);
    localparam logic [14:0] VOICE_LIMIT = 15'(VOICES);

    // configuration registers
    logic [8:0] sound_count_reg;
    logic [6:0] master_volume_reg;

    // voice tables
    logic signed [15:0] sound_tab_reg [VOICES];
    logic signed [31:0] prio_tab_reg  [VOICES];
    logic               loop_tab_reg  [VOICES];
    logic signed [15:0] saved_sound_reg [VOICES];
    logic signed [31:0] saved_prio_reg  [VOICES];
    logic               saved_loop_reg  [VOICES];

    // captured request
    op_t                op_reg;
    logic signed [15:0] snd_reg;
    logic [VOICE_W-1:0] vc_reg;
    logic               vc_ok_reg;
    logic               snd_ok_reg;
    logic [6:0]         bal_reg;
    logic [7:0]         loud_reg;
    logic signed [31:0] pri_reg;

    // decision and level pipeline
    logic [VOICE_W-1:0] low_reg;
    logic               take_reg;
    logic [VOICES-1:0]  mask_reg;
    logic [14:0]        prod_l_reg, prod_r_reg;
    logic [21:0]        sc_l_reg, sc_r_reg;
    logic [7:0]         lvl_l_reg, lvl_r_reg;

    // combinational helpers
    logic [6:0]         bal_clamp;
    logic signed [31:0] pri_next;
    logic               snd_ok_next;
    logic               vc_ok_next;
    logic [VOICE_W-1:0] low_next;
    logic [VOICES-1:0]  mask_next;
    logic [6:0]         factor;
    logic [36:0]        quo_l_full, quo_r_full;
    logic [8:0]         quo_l, quo_r;

    // result candidate for the current step
    cmd_code_t                res_cmd;
    logic [VOICE_W-1:0]       res_tv;
    logic [7:0]               res_snd;
    logic [7:0]               res_left, res_right;
    logic signed [PLAY_W-1:0] res_pr;
    logic                     res_play;
    logic                     res_emit, res_last;
    logic [VOICE_W-1:0]       vidx;
    logic                     later_hit;
    logic                     last_voice;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sound_count_reg   <= 9'd0;
            master_volume_reg <= 7'd100;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_SOUND_COUNT:   sound_count_reg   <= cfg_data[8:0];
                REG_MASTER_VOLUME: master_volume_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // request decode ahead of capture
    always_comb begin
        if (s_balance[7]) begin
            bal_clamp = 7'd0;
        end else if (s_balance > 8'sd100) begin
            bal_clamp = 7'd100;
        end else begin
            bal_clamp = s_balance[6:0];
        end
        if (s_operation == OP_LOOP) begin
            pri_next = PRIO_LOOP;
        end else if (s_request_priority == PRIO_MAX) begin
            pri_next = s_request_priority;
        end else begin
            pri_next = s_request_priority + 32'sd1;
        end
        snd_ok_next = !s_sound_index[15]
                      && ({1'b0, s_sound_index[14:0]} < {7'd0, sound_count_reg})
                      && ({2'b0, s_sound_index[14:0]} < SLOT_LIMIT);
        vc_ok_next  = !s_voice[15] && (s_voice[14:0] < VOICE_LIMIT);
    end

    // capture on input transfer
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= op_t'(s_operation);
            snd_reg    <= s_sound_index;
            vc_reg     <= s_voice[VOICE_W-1:0];
            vc_ok_reg  <= vc_ok_next;
            snd_ok_reg <= snd_ok_next;
            bal_reg    <= bal_clamp;
            loud_reg   <= s_loudness;
            pri_reg    <= pri_next;
        end
    end

    // lowest priority voice, first on a tie, and sound match per voice
    always_comb begin
        low_next = '0;
        for (int n = 1; n < VOICES; n++) begin
            if (prio_tab_reg[n] < prio_tab_reg[low_next]) begin
                low_next = VOICE_W'(n);
            end
        end
        for (int n = 0; n < VOICES; n++) begin
            mask_next[n] = (sound_tab_reg[n] == snd_reg);
        end
    end

    // level pipeline: loudness times balance, times scale, then divide
    assign factor     = (op_reg == OP_PLAY || op_reg == OP_LOOP) ? master_volume_reg : 7'd100;
    assign quo_l_full = 37'(sc_l_reg[21:4]) * 37'(RECIP_625);
    assign quo_r_full = 37'(sc_r_reg[21:4]) * 37'(RECIP_625);
    assign quo_l      = quo_l_full[RECIP_SHIFT+8:RECIP_SHIFT];
    assign quo_r      = quo_r_full[RECIP_SHIFT+8:RECIP_SHIFT];

    always_ff @(posedge aclk) begin
        if (cmd.prod) begin
            prod_r_reg <= {7'd0, loud_reg} * {8'd0, bal_reg};
            prod_l_reg <= {7'd0, loud_reg} * {8'd0, 7'd100 - bal_reg};
            low_reg    <= low_next;
            take_reg   <= snd_ok_reg
                          && (op_reg == OP_LOOP || pri_reg > prio_tab_reg[low_next]);
            mask_reg   <= mask_next;
        end
        if (cmd.scale) begin
            sc_l_reg <= 22'(prod_l_reg) * 22'(factor);
            sc_r_reg <= 22'(prod_r_reg) * 22'(factor);
        end
        if (cmd.quot) begin
            lvl_l_reg <= quo_l[8] ? 8'hff : quo_l[7:0];
            lvl_r_reg <= quo_r[8] ? 8'hff : quo_r[7:0];
        end
    end

    // result of the current step
    assign vidx       = cmd.step[VOICE_W-1:0];
    assign last_voice = (cmd.step == STEP_W'(VOICES - 1));

    always_comb begin
        later_hit = 1'b0;
        for (int n = 0; n < VOICES; n++) begin
            if (VOICE_W'(n) > vidx && mask_reg[n]) begin
                later_hit = 1'b1;
            end
        end
    end

    always_comb begin
        res_cmd   = CMD_NONE;
        res_tv    = '0;
        res_snd   = 8'd0;
        res_left  = 8'd0;
        res_right = 8'd0;
        res_pr    = '1;
        res_play  = 1'b0;
        res_emit  = 1'b1;
        res_last  = 1'b1;
        unique case (op_reg)
            OP_PLAY, OP_LOOP: begin
                if (take_reg) begin
                    res_tv   = low_reg;
                    res_last = (cmd.step == STEP_W'(2));
                    if (op_reg == OP_PLAY) begin
                        res_pr = {1'b0, low_reg};
                    end
                    if (cmd.step == STEP_W'(0)) begin
                        res_cmd = CMD_SILENCE;
                    end else if (cmd.step == STEP_W'(1)) begin
                        res_cmd   = CMD_START;
                        res_snd   = snd_reg[7:0];
                        res_left  = lvl_l_reg;
                        res_right = lvl_r_reg;
                    end else begin
                        res_cmd = CMD_NOTIFY;
                    end
                end
            end
            OP_STOP_SOUND, OP_MOVE_SOUND: begin
                if (mask_reg != '0) begin
                    res_tv   = vidx;
                    res_emit = mask_reg[vidx];
                    res_last = !later_hit;
                    if (op_reg == OP_STOP_SOUND) begin
                        res_cmd = CMD_SILENCE;
                    end else begin
                        res_cmd   = CMD_SET_VOL;
                        res_left  = lvl_l_reg;
                        res_right = lvl_r_reg;
                    end
                end
            end
            OP_STOP_VOICE: begin
                if (vc_ok_reg) begin
                    res_cmd = CMD_SILENCE;
                    res_tv  = vc_reg;
                end
            end
            OP_MOVE_VOICE: begin
                if (vc_ok_reg) begin
                    res_cmd   = CMD_SET_VOL;
                    res_tv    = vc_reg;
                    res_left  = lvl_l_reg;
                    res_right = lvl_r_reg;
                end
            end
            OP_PAUSE, OP_STOP_ALL: begin
                res_cmd  = CMD_SILENCE;
                res_tv   = vidx;
                res_last = last_voice;
            end
            OP_RESUME: begin
                res_cmd  = CMD_NOTIFY;
                res_tv   = vidx;
                res_last = last_voice;
            end
            OP_FINISHED: begin
                if (vc_ok_reg && loop_tab_reg[vc_reg]) begin
                    res_cmd = CMD_RESTART;
                    res_tv  = vc_reg;
                    res_snd = sound_tab_reg[vc_reg][7:0];
                end
            end
            OP_QUERY_SND: begin
                res_play = (mask_reg != '0);
            end
            OP_QUERY_VOICE: begin
                res_play = vc_ok_reg && (sound_tab_reg[vc_reg] != -16'sd1);
            end
            default: ;
        endcase
    end

    assign stat.emit = res_emit;
    assign stat.last = res_last;

    // voice table updates on each result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < VOICES; n++) begin
                sound_tab_reg[n]   <= -16'sd1;
                prio_tab_reg[n]    <= PRIO_RESET;
                loop_tab_reg[n]    <= 1'b0;
                saved_sound_reg[n] <= -16'sd1;
                saved_prio_reg[n]  <= PRIO_RESET;
                saved_loop_reg[n]  <= 1'b0;
            end
        end else if (cmd.fire) begin
            case (op_reg)
                OP_PLAY, OP_LOOP: begin
                    if (take_reg && cmd.step == STEP_W'(0)) begin
                        sound_tab_reg[low_reg] <= snd_reg;
                        prio_tab_reg[low_reg]  <= pri_reg;
                        loop_tab_reg[low_reg]  <= (op_reg == OP_LOOP);
                    end
                end
                OP_STOP_SOUND: begin
                    if (mask_reg[vidx]) begin
                        sound_tab_reg[vidx] <= -16'sd1;
                        prio_tab_reg[vidx]  <= 32'sd0;
                        loop_tab_reg[vidx]  <= 1'b0;
                    end
                end
                OP_STOP_VOICE: begin
                    if (vc_ok_reg) begin
                        sound_tab_reg[vc_reg] <= -16'sd1;
                        prio_tab_reg[vc_reg]  <= 32'sd0;
                        loop_tab_reg[vc_reg]  <= 1'b0;
                    end
                end
                OP_PAUSE, OP_STOP_ALL: begin
                    if (op_reg == OP_PAUSE && cmd.step == STEP_W'(0)) begin
                        for (int n = 0; n < VOICES; n++) begin
                            saved_sound_reg[n] <= sound_tab_reg[n];
                            saved_prio_reg[n]  <= prio_tab_reg[n];
                            saved_loop_reg[n]  <= loop_tab_reg[n];
                        end
                    end
                    sound_tab_reg[vidx] <= -16'sd1;
                    prio_tab_reg[vidx]  <= 32'sd0;
                    loop_tab_reg[vidx]  <= 1'b0;
                end
                OP_RESUME: begin
                    if (cmd.step == STEP_W'(0)) begin
                        for (int n = 0; n < VOICES; n++) begin
                            sound_tab_reg[n] <= saved_sound_reg[n];
                            prio_tab_reg[n]  <= saved_prio_reg[n];
                            loop_tab_reg[n]  <= saved_loop_reg[n];
                        end
                    end
                end
                OP_FINISHED: begin
                    if (vc_ok_reg && !loop_tab_reg[vc_reg]) begin
                        sound_tab_reg[vc_reg] <= -16'sd1;
                        prio_tab_reg[vc_reg]  <= 32'sd0;
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.fire) begin
            m_command      <= res_cmd;
            m_target_voice <= res_tv;
            m_sound_out    <= res_snd;
            m_left_level   <= res_left;
            m_right_level  <= res_right;
            m_play_result  <= res_pr;
            m_is_playing   <= res_play;
            m_last         <= res_last;
        end
    end

endmodule

@@ rtl/pva_ctrl.sv @@
// controller of the voice allocator: sequencing and handshakes
`timescale 1ns / 1ps

module pva_ctrl import pva_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  pva_stat_t stat,
    output pva_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_SCALE,
        ST_QUOT,
        ST_STEP,
        ST_WAIT
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              last_reg;

    // handshakes follow the state
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_WAIT);

    // datapath commands
    assign cmd.capture = (state_reg == ST_IDLE) && s_valid;
    assign cmd.prod    = (state_reg == ST_PROD);
    assign cmd.scale   = (state_reg == ST_SCALE);
    assign cmd.quot    = (state_reg == ST_QUOT);
    assign cmd.fire    = (state_reg == ST_STEP) && stat.emit;
    assign cmd.step    = step_reg;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            last_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_PROD;
                        step_reg  <= '0;
                    end
                end
                ST_PROD:  state_reg <= ST_SCALE;
                ST_SCALE: state_reg <= ST_QUOT;
                ST_QUOT:  state_reg <= ST_STEP;
                ST_STEP: begin
                    if (stat.emit) begin
                        last_reg  <= stat.last;
                        state_reg <= ST_WAIT;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_WAIT: begin
                    if (m_ready) begin
                        if (last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            step_reg  <= step_reg + 1'b1;
                            state_reg <= ST_STEP;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_fire_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fire |=> m_valid)
        else $error("loaded result not presented");

    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && last_reg |=> s_ready)
        else $error("not ready after final result transfer");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_STEP |-> {1'b0, step_reg} < (STEP_W + 1)'(STEPS))
        else $error("step counter out of range");

endmodule

@@ rtl/priority_voice_allocator_unit.sv @@
// Priority voice allocator: one request at a time, one to STEPS results per request.
// The first result passes through the product, scale and divide registers before the
// result load; each further result waits for the previous one to be taken, and voices
// with nothing to report are skipped. A new request is taken only after the final result.
// Reset (aresetn, synchronous, active low): idle, voice tables at their reset values,
// sound count 0, master volume 100.
`timescale 1ns / 1ps

module priority_voice_allocator_unit import pva_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [3:0]                  s_operation,
    input  logic signed [15:0]          s_sound_index,
    input  logic signed [15:0]          s_voice,
    input  logic signed [7:0]           s_balance,
    input  logic [7:0]                  s_loudness,
    input  logic signed [31:0]          s_request_priority,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [2:0]                  m_command,
    output logic [VOICE_W-1:0]          m_target_voice,
    output logic [7:0]                  m_sound_out,
    output logic [7:0]                  m_left_level,
    output logic [7:0]                  m_right_level,
    output logic signed [PLAY_W-1:0]    m_play_result,
    output logic                        m_is_playing,
    output logic                        m_last
);

    pva_cmd_t  cmd;
    pva_stat_t stat;

    // sequencing and handshakes
    pva_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // tables, arithmetic and result register
    pva_dpath u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_operation        (s_operation),
        .s_sound_index      (s_sound_index),
        .s_voice            (s_voice),
        .s_balance          (s_balance),
        .s_loudness         (s_loudness),
        .s_request_priority (s_request_priority),
        .cmd                (cmd),
        .stat               (stat),
        .m_command          (m_command),
        .m_target_voice     (m_target_voice),
        .m_sound_out        (m_sound_out),
        .m_left_level       (m_left_level),
        .m_right_level      (m_right_level),
        .m_play_result      (m_play_result),
        .m_is_playing       (m_is_playing),
        .m_last             (m_last)
    );

endmodule
